// ----- hw/rtl/rational_arithmetic_unit_defines.svh -----
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (prop)) \
    else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk_s, rst_s, prop)
`define RAU_ASSERT_NEXT(label, clk_s, rst_s, pre, post)
`endif
`endif

// ----- hw/rtl/rau_pkg.sv -----
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
  localparam int IN_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3, OP_CMP = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_LT = 2'd2;

  // classified job handed from front to back
  typedef struct packed {
    logic        skip;     // result fixed, no reduction needed
    logic [1:0]  status;
    logic [1:0]  cmp;
    logic        neg;
    logic [63:0] nmag;
    logic [63:0] dmag;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_GCD, BK_DIVN, BK_DIVD, BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rau_front.sv -----
// front end: sign split, cross products, sums and classification
`default_nettype none
module rau_front
  import rau_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [31:0] a_num,
  input  wire logic [31:0] a_den,
  input  wire logic [31:0] b_num,
  input  wire logic [31:0] b_den,
  output logic             job_valid,
  input  wire logic        job_ready,
  output job_t             job
);
  // stage 1: magnitudes and products
  logic        s1_v_r;
  logic [2:0]  s1_op_r;
  logic        s1_zd_r;
  logic [63:0] p1_r, p2_r, pd_r;
  logic        p1n_r, p2n_r, pdn_r;
  logic        s2_v_r;
  job_t        s2_r, s2_nxt;

  function automatic logic [IN_WIDTH-1:0] mag_of(input logic [31:0] raw);
    logic [IN_WIDTH-1:0] v;
    v = raw[IN_WIDTH-1:0];
    return v[IN_WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  logic [IN_WIDTH-1:0] anm, adm, bnm, bdm;
  logic ans, ads, bns, bds;
  assign anm = mag_of(a_num);
  assign adm = mag_of(a_den);
  assign bnm = mag_of(b_num);
  assign bdm = mag_of(b_den);
  assign ans = a_num[IN_WIDTH-1];
  assign ads = a_den[IN_WIDTH-1];
  assign bns = b_num[IN_WIDTH-1];
  assign bds = b_den[IN_WIDTH-1];

  logic [IN_WIDTH-1:0] x1, y1, x2, y2, xd, yd;
  logic xs1, ys1, xs2, ys2, xsd, ysd;
  always_comb begin
    x1 = anm; y1 = bdm; xs1 = ans; ys1 = bds;
    x2 = adm; y2 = bnm; xs2 = ads; ys2 = bns;
    xd = adm; yd = bdm; xsd = ads; ysd = bds;
    if (req_type == OP_MUL) begin
      y1 = bnm; ys1 = bns;
    end else if (req_type == OP_DIV) begin
      yd = bnm; ysd = bns;
    end
  end

  logic s1_adv, s2_adv;
  assign s2_adv = !s2_v_r || job_ready;
  assign s1_adv = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= in_valid;
      if (s2_adv) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_op_r <= req_type;
      s1_zd_r <= (adm == '0) || (bdm == '0) || (req_type == OP_DIV && bnm == '0);
      p1_r <= 64'(x1) * 64'(y1);
      p2_r <= 64'(x2) * 64'(y2);
      pd_r <= 64'(xd) * 64'(yd);
      p1n_r <= xs1 ^ ys1;
      p2n_r <= xs2 ^ ys2;
      pdn_r <= xsd ^ ysd;
    end
    if (s2_adv) s2_r <= s2_nxt;
  end

  always_comb begin
    logic n1, n2, nn;
    logic [63:0] m;
    n1 = p1n_r && p1_r != 0;
    n2 = p2n_r && p2_r != 0;
    if ((s1_op_r == OP_SUB || s1_op_r == OP_CMP) && p2_r != 0) n2 = !n2;
    m = p1_r;
    nn = n1;
    if (s1_op_r == OP_ADD || s1_op_r == OP_SUB || s1_op_r == OP_CMP) begin
      if (n1 == n2) begin
        m = p1_r + p2_r;
      end else if (p1_r >= p2_r) begin
        m = p1_r - p2_r;
      end else begin
        m = p2_r - p1_r;
        nn = n2;
      end
    end else if (s1_op_r == OP_MUL) begin
      m = p1_r;
    end
    s2_nxt.nmag = m;
    s2_nxt.dmag = pd_r;
    s2_nxt.neg = (m != 0) && (nn != (pdn_r && pd_r != 0));
    s2_nxt.skip = 1'b0;
    s2_nxt.status = ST_OK;
    s2_nxt.cmp = CMP_EQ;
    if (s1_op_r > OP_CMP) begin
      s2_nxt.skip = 1'b1;
    end else if (s1_zd_r) begin
      s2_nxt.skip = 1'b1;
      s2_nxt.status = ST_ZDEN;
    end else if (s1_op_r == OP_CMP) begin
      s2_nxt.skip = 1'b1;
      s2_nxt.cmp = (m == 0) ? CMP_EQ : (s2_nxt.neg ? CMP_LT : CMP_GT);
    end
  end

  assign job_valid = s2_v_r;
  assign job = s2_r;
endmodule
`default_nettype wire

// ----- hw/rtl/rau_queue.sv -----
// short fifo between front and back
`default_nettype none
module rau_queue
  import rau_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_data
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  `include "rational_arithmetic_unit_defines.svh"
  `RAU_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= 2'd2)
  `RAU_ASSERT_NEXT(a_full_hold, clk, rst_n, cnt_r == 2'd2 && !rd, cnt_r == 2'd2)
  `RAU_ASSERT_NEXT(a_empty_hold, clk, rst_n, cnt_r == 2'd0 && !wr, cnt_r == 2'd0)
endmodule
`default_nettype wire

// ----- hw/rtl/rau_back.sv -----
// back end: euclidean gcd, exact divisions and result register
`default_nettype none
module rau_back
  import rau_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  job_t              job,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [130:0]      out_tdata
);
  bk_state_t   st_r, st_nxt;
  job_t        j_r;
  logic [63:0] u_r, v_r, g_r;
  // restoring divider shared by modulo and quotient steps
  logic [63:0] dq_r, dr_r, dd_r;
  logic [6:0]  dc_r;
  logic        dbusy_r;
  logic [63:0] qn_r;
  logic [130:0] res_r, res_nxt;
  logic         ov_r;

  logic [64:0] trial;
  logic [63:0] rem_sh;
  assign rem_sh = {dr_r[62:0], dq_r[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, dd_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: if (job_valid) st_nxt = job.skip ? BK_OUT : BK_GCD;
      BK_GCD:  if (!dbusy_r && v_r == 64'd0) st_nxt = BK_DIVN;
      BK_DIVN: if (dbusy_r && dc_r == 7'd0) st_nxt = BK_DIVD;
      BK_DIVD: if (dbusy_r && dc_r == 7'd0) st_nxt = BK_OUT;
      BK_OUT:  if (!ov_r || out_tready) st_nxt = ov_r ? BK_IDLE : BK_OUT;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == BK_IDLE);
  end

  // result word: num, den, cmp, status from the lowest bit up
  always_comb begin
    res_nxt = '0;
    res_nxt[130:129] = j_r.status;
    res_nxt[128:127] = j_r.cmp;
    if (!j_r.skip) begin
      if (!j_r.neg && qn_r[63]) begin
        res_nxt[130:129] = ST_OVF;
      end else begin
        res_nxt[63:0] = j_r.neg ? (~qn_r + 64'd1) : qn_r;
        res_nxt[126:64] = dq_r[62:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (st_r == BK_OUT && !ov_r) ov_r <= 1'b1;
      if (st_r == BK_GCD) begin
        if (!dbusy_r && v_r != 64'd0) dbusy_r <= 1'b1;
        else if (dbusy_r && dc_r == 7'd0) dbusy_r <= 1'b0;
      end else if (st_r == BK_DIVN || st_r == BK_DIVD) begin
        if (!dbusy_r) dbusy_r <= 1'b1;
        else if (dc_r == 7'd0) dbusy_r <= 1'b0;
      end else begin
        dbusy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: begin
        j_r <= job;
        u_r <= job.nmag;
        v_r <= job.dmag;
      end
      BK_GCD: begin
        if (!dbusy_r) begin
          if (v_r == 64'd0) g_r <= u_r;
          dq_r <= u_r; dr_r <= '0; dd_r <= v_r; dc_r <= 7'd63;
        end else begin
          dq_r <= {dq_r[62:0], !trial[64]};
          dr_r <= trial[64] ? rem_sh : trial[63:0];
          dc_r <= dc_r - 7'd1;
          if (dc_r == 7'd0) begin
            u_r <= v_r;
            v_r <= trial[64] ? rem_sh : trial[63:0];
          end
        end
      end
      BK_DIVN, BK_DIVD: begin
        if (!dbusy_r) begin
          dq_r <= (st_r == BK_DIVN) ? j_r.nmag : j_r.dmag;
          dr_r <= '0; dd_r <= g_r; dc_r <= 7'd63;
        end else begin
          dq_r <= {dq_r[62:0], !trial[64]};
          dr_r <= trial[64] ? rem_sh : trial[63:0];
          dc_r <= dc_r - 7'd1;
          if (dc_r == 7'd0 && st_r == BK_DIVN) qn_r <= {dq_r[62:0], !trial[64]};
        end
      end
      BK_OUT: begin
        if (!ov_r) res_r <= res_nxt;
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata = res_r;

  `include "rational_arithmetic_unit_defines.svh"
  `RAU_ASSERT(a_ready_idle, clk, rst_n, !job_ready || !ov_r || st_r == BK_IDLE)
  `RAU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `RAU_ASSERT(a_gcd_nz, clk, rst_n, !(st_r == BK_DIVN) || g_r != 64'd0)
endmodule
`default_nettype wire

// ----- hw/rtl/rational_arithmetic_unit.sv -----
// rational arithmetic unit: front end, job queue, gcd back end
// flow: the front end registers the cross products, then the sum and class;
// the back end runs euclid's gcd, one divider pass per step, then divides
// num and den by the gcd; compare, error and unknown ops skip gcd and divides
// the back end takes a new job only when idle, after its last result is taken
// reset: synchronous active-low rst_n clears all control state, queue empty
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int IN_WIDTH = IN_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  wire logic [2:0]   in_tuser,   // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata   // res_num, res_den, cmp_result, status
);
  logic  fj_v, fj_r, qj_v, qj_r;
  job_t  fj, qj;
  logic [130:0] bd;

  rau_front #(.IN_WIDTH(IN_WIDTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .req_type(in_tuser), .a_num(in_tdata[31:0]), .a_den(in_tdata[63:32]),
    .b_num(in_tdata[95:64]), .b_den(in_tdata[127:96]),
    .job_valid(fj_v), .job_ready(fj_r), .job(fj));
  rau_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_v), .wr_ready(fj_r), .wr_data(fj),
    .rd_valid(qj_v), .rd_ready(qj_r), .rd_data(qj));
  rau_back u_back (
    .clk, .rst_n, .job_valid(qj_v), .job_ready(qj_r), .job(qj),
    .out_tvalid, .out_tready, .out_tdata(bd));
  assign out_tdata = {5'd0, bd};
endmodule
`default_nettype wire

// ----- bench/rational_arithmetic_unit_tb.sv -----
// self-checking testbench for the rational arithmetic unit
`default_nettype none
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] bd;
    logic [31:0] bn;
    logic [31:0] ad;
    logic [31:0] an;
  } frac_req_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [1:0]  cmp;
    logic [62:0] den;
    logic [63:0] num;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 73;
  bit in_acc = 1'b0;
  bit drain_done = 1'b0;

  rational_arithmetic_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // split a 32-bit field into sign and magnitude
  function automatic void to_sm(input logic [31:0] raw, output bit neg,
                                output logic [63:0] mag);
    neg = raw[31];
    mag = neg ? (64'd0 - {{32{raw[31]}}, raw}) : {32'd0, raw};
  endfunction

  function automatic void sm_mul(input bit xn, input logic [63:0] xm, input bit yn,
                                 input logic [63:0] ym, output bit rn,
                                 output logic [63:0] rm);
    rm = xm * ym;
    rn = (rm != 0) && (xn != yn);
  endfunction

  function automatic void sm_add(input bit xn, input logic [63:0] xm, input bit yn,
                                 input logic [63:0] ym, output bit rn,
                                 output logic [63:0] rm);
    if (xn == yn) begin
      rm = xm + ym;
      rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym;
      rn = xn;
    end else begin
      rm = ym - xm;
      rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic frac_res_t reduce_fraction(input frac_req_t r);
    frac_res_t res;
    bit an_s, ad_s, bn_s, bd_s, p_s, q_s, num_s, den_s, neg;
    logic [63:0] an_m, ad_m, bn_m, bd_m, p_m, q_m, num_m, den_m, u, v, t, nm, dm;
    res = '0;
    to_sm(r.an, an_s, an_m);
    to_sm(r.ad, ad_s, ad_m);
    to_sm(r.bn, bn_s, bn_m);
    to_sm(r.bd, bd_s, bd_m);
    if (r.op > OP_CMP) return res;
    if (ad_m == 0 || bd_m == 0 || (r.op == OP_DIV && bn_m == 0)) begin
      res.st = ST_ZDEN;
      return res;
    end
    case (r.op)
      OP_ADD, OP_SUB, OP_CMP: begin
        sm_mul(an_s, an_m, bd_s, bd_m, p_s, p_m);
        sm_mul(ad_s, ad_m, bn_s, bn_m, q_s, q_m);
        if (r.op != OP_ADD && q_m != 0) q_s = !q_s;
        sm_add(p_s, p_m, q_s, q_m, num_s, num_m);
        sm_mul(ad_s, ad_m, bd_s, bd_m, den_s, den_m);
      end
      OP_MUL: begin
        sm_mul(an_s, an_m, bn_s, bn_m, num_s, num_m);
        sm_mul(ad_s, ad_m, bd_s, bd_m, den_s, den_m);
      end
      default: begin
        sm_mul(an_s, an_m, bd_s, bd_m, num_s, num_m);
        sm_mul(ad_s, ad_m, bn_s, bn_m, den_s, den_m);
      end
    endcase
    neg = (num_m != 0) && (num_s != den_s);
    if (r.op == OP_CMP) begin
      res.cmp = (num_m == 0) ? CMP_EQ : (neg ? CMP_LT : CMP_GT);
      return res;
    end
    u = num_m;
    v = den_m;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    nm = num_m / u;
    dm = den_m / u;
    if (!neg && nm[63]) begin
      res.st = ST_OVF;
      return res;
    end
    res.num = neg ? (64'd0 - nm) : nm;
    res.den = dm[62:0];
    return res;
  endfunction

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 ^ $urandom_range(3);
      2: return 32'h7fff_ffff - $urandom_range(3);
      3: return 32'd0 - $urandom_range(40);
      default: return $urandom_range(60);
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] op, input logic [31:0] an, ad, bn, bd);
    frac_req_t r;
    r.op = op;
    r.an = an;
    r.ad = ad;
    r.bn = bn;
    r.bd = bd;
    pending_reqs.push_back(r);
  endtask

  initial begin
    frac_req_t r;
    logic [2:0] op;
    // directed: extremes, zero results, zero denominators, unknown ops
    queue_req(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd2);
    queue_req(OP_SUB, 32'd3, 32'd4, 32'd3, 32'd4);
    queue_req(OP_MUL, 32'd0, 32'd7, 32'd5, 32'd9);
    queue_req(OP_DIV, 32'd6, 32'hffff_fffd, 32'd4, 32'd5);
    queue_req(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd3);
    queue_req(OP_CMP, 32'd2, 32'd3, 32'd1, 32'd3);
    queue_req(OP_CMP, 32'hffff_ffff, 32'd3, 32'd1, 32'd3);
    queue_req(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
    queue_req(OP_MUL, 32'd1, 32'd2, 32'd1, 32'd0);
    queue_req(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    queue_req(OP_CMP, 32'd1, 32'd0, 32'd1, 32'd1);
    queue_req(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
    queue_req(3'd6, 32'd1, 32'd0, 32'd3, 32'd4);
    queue_req(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_req(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    queue_req(OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
    queue_req(OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(OP_DIV, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd3);
    queue_req(OP_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_fffd);
    queue_req(OP_CMP, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
    repeat (1700) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      r.op = op;
      r.an = rand_field();
      r.bn = rand_field();
      r.ad = ($urandom_range(29) == 0) ? 32'd0 : rand_field();
      r.bd = ($urandom_range(29) == 0) ? 32'd0 : rand_field();
      if (r.ad == 0 && $urandom_range(1)) r.ad = 32'd1;
      if (r.bd == 0 && $urandom_range(1)) r.bd = 32'd1;
      pending_reqs.push_back(r);
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_tvalid && expected_fracs.size() == 0);
    repeat (300) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000_000);
    $display("FAILURE");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    frac_req_t r;
    bit drive;
    if (rst_n) begin
      if (n_accepted < 580) begin
        send_idle_pct = 12;
        recv_idle_pct = 73;
      end else if (n_accepted < 1160) begin
        send_idle_pct = 73;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_tvalid || in_acc) begin
        drive = pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct;
        // hold off once until the unit has drained
        if (n_accepted >= 600 && !drain_done) begin
          if (expected_fracs.size() == 0) drain_done = 1'b1;
          else drive = 1'b0;
        end
        if (drive) begin
          r = pending_reqs.pop_front();
          in_tdata <= {r.bd, r.bn, r.ad, r.an};
          in_tuser <= r.op;
        end
        in_tvalid <= drive;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_req_t r;
    frac_res_t got, want;
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      r = {in_tuser, in_tdata[127:96], in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]};
      expected_fracs.push_back(reduce_fraction(r));
      n_accepted <= n_accepted + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[130:0];
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected transaction %h", $time, got);
        n_errors <= n_errors + 1;
      end else begin
        want = expected_fracs.pop_front();
        if (got.num !== want.num || got.den !== want.den || got.cmp !== want.cmp ||
            got.st !== want.st) begin
          $display("%0t: mismatch expected num %h den %h cmp %0d st %0d",
                   $time, want.num, want.den, want.cmp, want.st);
          $display("%0t:          actual   num %h den %h cmp %0d st %0d",
                   $time, got.num, got.den, got.cmp, got.st);
          n_errors <= n_errors + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rational_arithmetic_unit.f -----
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_front.sv
hw/rtl/rau_queue.sv
hw/rtl/rau_back.sv
hw/rtl/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_tb.sv
